@@ hw/rtl/atids_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atids_pkg
// Shared widths, command codes and status codes of the sorted table unit.
// ----------------------------------------------------------------------------
package atids_pkg;

	localparam int TABLE_DEPTH_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 5;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT  = 3'd0,
		CMD_DELETE  = 3'd1,
		CMD_SORT    = 3'd2,
		CMD_REVERSE = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_BAD_INDEX = 2'd3
	} status_t;

endpackage

@@ hw/rtl/array_table_insert_delete_sort_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_table_insert_delete_sort_unit
// Packed table of signed 32-bit entries in a single-port-read synchronous RAM,
// with insert, delete, bubble sort, reverse and read commands.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | fields
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | command[2:0] value[31:0] index[4:0]
//  out     | out_valid / out_ready| status[1:0] position[4:0] data[31:0]
//          |                      | count[5:0] sorted
//
//  One item at a time; every RAM read is registered. Insert shifts greater
//  entries up from the top, or appends when unordered; delete scans, then
//  shifts down in order, or when unordered fills the hole with the last
//  entry and rechecks order; reverse swaps pairs and then rescans order;
//  sort runs bubble passes.
//  Reset clears count and sets the sorted flag; RAM contents stay undefined.
//  A new item is taken while the previous result waits; a finished item
//  stalls only while the output register still holds an untaken result.
//
module array_table_insert_delete_sort_unit
	import atids_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [CMD_W-1:0]           command,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [INDEX_W-1:0]         index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic [POS_W-1:0]           position,
	output logic signed [VALUE_W-1:0]  data,
	output logic [COUNT_W-1:0]         count,
	output logic                       sorted
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int NS = 23;

	typedef enum logic [NS-1:0] {
		ST_IDLE      = NS'(1) << 0,
		ST_INS_RD    = NS'(1) << 1,
		ST_INS_CMP   = NS'(1) << 2,
		ST_DEL_RD    = NS'(1) << 3,
		ST_DEL_CMP   = NS'(1) << 4,
		ST_DEL_SHRD  = NS'(1) << 5,
		ST_DEL_SHWR  = NS'(1) << 6,
		ST_DEL_LAST  = NS'(1) << 7,
		ST_DEL_FILL  = NS'(1) << 8,
		ST_RD_ISSUE  = NS'(1) << 9,
		ST_RD_WAIT   = NS'(1) << 10,
		ST_SRT_RD0   = NS'(1) << 11,
		ST_SRT_LD    = NS'(1) << 12,
		ST_SRT_CMP   = NS'(1) << 13,
		ST_SRT_END   = NS'(1) << 14,
		ST_REV_RDLO  = NS'(1) << 15,
		ST_REV_RDHI  = NS'(1) << 16,
		ST_REV_WRLO  = NS'(1) << 17,
		ST_REV_WRHI  = NS'(1) << 18,
		ST_CHK_START = NS'(1) << 19,
		ST_CHK_LD    = NS'(1) << 20,
		ST_CHK_CMP   = NS'(1) << 21,
		ST_FINISH    = NS'(1) << 22
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic                sorted_q;
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       pass_q;
	logic                moved_q;
	logic [VALUE_W-1:0]  carry_q;
	logic [VALUE_W-1:0]  val_q;
	logic [INDEX_W-1:0]  idx_q;
	status_t             r_status_q;
	logic [POS_W-1:0]    r_pos_q;
	logic [VALUE_W-1:0]  r_data_q;

	logic                out_valid_q;
	status_t             status_q;
	logic [POS_W-1:0]    position_q;
	logic [VALUE_W-1:0]  data_q;
	logic [COUNT_W-1:0]  count_out_q;
	logic                sorted_out_q;

	logic [VALUE_W-1:0]  mem_q [TABLE_DEPTH];
	logic [VALUE_W-1:0]  rd_data_q;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [VALUE_W-1:0]  wr_data;

	logic [CW-1:0]       lim;
	logic                gt_ins;
	logic                gt_carry;

	// compares left in the current bubble pass
	assign lim      = count_q - CW'(1) - pass_q;
	assign gt_ins   = $signed(rd_data_q) > $signed(val_q);
	assign gt_carry = $signed(carry_q) > $signed(rd_data_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign data      = data_q;
	assign count     = count_out_q;
	assign sorted    = sorted_out_q;

	// RAM port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = val_q;
		case (state_q)
			ST_INS_RD: begin
				if (i_q == '0 || !sorted_q) begin
					wr_en   = 1'b1;
					wr_addr = i_q[AW-1:0];
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(i_q - CW'(1));
				end
			end
			ST_INS_CMP: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = gt_ins ? rd_data_q : val_q;
			end
			ST_DEL_RD: begin
				rd_en   = (i_q != count_q);
				rd_addr = i_q[AW-1:0];
			end
			ST_DEL_SHRD: begin
				rd_en   = (i_q + CW'(1) < count_q);
				rd_addr = AW'(i_q + CW'(1));
			end
			ST_DEL_SHWR: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = rd_data_q;
			end
			ST_DEL_LAST: begin
				rd_en   = 1'b1;
				rd_addr = AW'(count_q - CW'(1));
			end
			ST_DEL_FILL: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = rd_data_q;
			end
			ST_RD_ISSUE: begin
				rd_en   = 1'b1;
				rd_addr = AW'(idx_q);
			end
			ST_SRT_RD0: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_SRT_LD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(1);
			end
			ST_SRT_CMP: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = gt_carry ? rd_data_q : carry_q;
				rd_en   = (j_q + CW'(1) < lim);
				rd_addr = AW'(j_q + CW'(2));
			end
			ST_SRT_END: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = carry_q;
			end
			ST_REV_RDLO: begin
				rd_en   = 1'b1;
				rd_addr = j_q[AW-1:0];
			end
			ST_REV_RDHI: begin
				rd_en   = 1'b1;
				rd_addr = i_q[AW-1:0];
			end
			ST_REV_WRLO: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = rd_data_q;
			end
			ST_REV_WRHI: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = carry_q;
			end
			ST_CHK_START: begin
				rd_en   = (count_q >= CW'(2));
				rd_addr = '0;
			end
			ST_CHK_LD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(1);
			end
			ST_CHK_CMP: begin
				rd_en   = !gt_carry && (i_q + CW'(1) < count_q);
				rd_addr = AW'(i_q + CW'(1));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sorted_q    <= 1'b1;
			i_q         <= '0;
			j_q         <= '0;
			pass_q      <= '0;
			moved_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the finish state reloads the output register itself
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						val_q    <= value;
						idx_q    <= index;
						r_data_q <= '0;
						case (command)
							CMD_INSERT: begin
								r_pos_q <= '0;
								if (count_q == CW'(TABLE_DEPTH)) begin
									r_status_q <= STAT_FULL;
									state_q    <= ST_FINISH;
								end else begin
									r_status_q <= STAT_OK;
									i_q        <= count_q;
									state_q    <= ST_INS_RD;
								end
							end
							CMD_DELETE: begin
								r_status_q <= STAT_OK;
								r_pos_q    <= '0;
								i_q        <= '0;
								state_q    <= ST_DEL_RD;
							end
							CMD_SORT: begin
								r_status_q <= STAT_OK;
								r_pos_q    <= '0;
								pass_q     <= '0;
								state_q <= (count_q < CW'(2)) ? ST_FINISH : ST_SRT_RD0;
							end
							CMD_REVERSE: begin
								r_status_q <= STAT_OK;
								r_pos_q    <= '0;
								j_q        <= '0;
								i_q        <= count_q - CW'(1);
								state_q <= (count_q < CW'(2)) ? ST_FINISH : ST_REV_RDLO;
							end
							CMD_READ: begin
								r_pos_q <= index;
								if (32'(index) >= 32'(count_q)) begin
									r_status_q <= STAT_BAD_INDEX;
									state_q    <= ST_FINISH;
								end else begin
									r_status_q <= STAT_OK;
									state_q    <= ST_RD_ISSUE;
								end
							end
							default: begin
								r_status_q <= STAT_OK;
								r_pos_q    <= '0;
								state_q    <= ST_FINISH;
							end
						endcase
					end
				end
				// insert walks down from the top, shifting greater entries up; an unordered table appends
				ST_INS_RD: begin
					if (i_q == '0 || !sorted_q) begin
						r_pos_q <= POS_W'(i_q);
						count_q <= count_q + CW'(1);
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_INS_CMP;
					end
				end
				ST_INS_CMP: begin
					if (gt_ins) begin
						i_q     <= i_q - CW'(1);
						state_q <= ST_INS_RD;
					end else begin
						r_pos_q <= POS_W'(i_q);
						count_q <= count_q + CW'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_DEL_RD: begin
					if (i_q == count_q) begin
						r_status_q <= STAT_NOT_FOUND;
						state_q    <= ST_FINISH;
					end else begin
						state_q <= ST_DEL_CMP;
					end
				end
				ST_DEL_CMP: begin
					if (rd_data_q == val_q) begin
						j_q     <= i_q;
						r_pos_q <= POS_W'(i_q);
						state_q <= sorted_q ? ST_DEL_SHRD : ST_DEL_LAST;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= ST_DEL_RD;
					end
				end
				ST_DEL_SHRD: begin
					if (i_q + CW'(1) < count_q) begin
						state_q <= ST_DEL_SHWR;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_DEL_SHWR: begin
					i_q     <= i_q + CW'(1);
					state_q <= ST_DEL_SHRD;
				end
				ST_DEL_LAST: begin
					state_q <= ST_DEL_FILL;
				end
				// last entry moved into the hole: order must be rechecked
				ST_DEL_FILL: begin
					count_q <= count_q - CW'(1);
					state_q <= ST_CHK_START;
				end
				ST_RD_ISSUE: begin
					state_q <= ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					r_data_q <= rd_data_q;
					state_q  <= ST_FINISH;
				end
				// bubble pass keeps the running maximum in carry_q
				ST_SRT_RD0: begin
					j_q     <= '0;
					moved_q <= 1'b0;
					state_q <= ST_SRT_LD;
				end
				ST_SRT_LD: begin
					carry_q <= rd_data_q;
					state_q <= ST_SRT_CMP;
				end
				ST_SRT_CMP: begin
					if (gt_carry) begin
						moved_q <= 1'b1;
					end else begin
						carry_q <= rd_data_q;
					end
					j_q <= j_q + CW'(1);
					if (!(j_q + CW'(1) < lim)) begin
						state_q <= ST_SRT_END;
					end
				end
				ST_SRT_END: begin
					pass_q <= pass_q + CW'(1);
					if (moved_q && (pass_q + CW'(2) < count_q)) begin
						state_q <= ST_SRT_RD0;
					end else begin
						sorted_q <= 1'b1;
						state_q  <= ST_FINISH;
					end
				end
				ST_REV_RDLO: begin
					state_q <= ST_REV_RDHI;
				end
				ST_REV_RDHI: begin
					carry_q <= rd_data_q;
					state_q <= ST_REV_WRLO;
				end
				ST_REV_WRLO: begin
					state_q <= ST_REV_WRHI;
				end
				ST_REV_WRHI: begin
					j_q     <= j_q + CW'(1);
					i_q     <= i_q - CW'(1);
					state_q <= (j_q + CW'(2) < i_q) ? ST_REV_RDLO : ST_CHK_START;
				end
				ST_CHK_START: begin
					if (count_q < CW'(2)) begin
						sorted_q <= 1'b1;
						state_q  <= ST_FINISH;
					end else begin
						state_q <= ST_CHK_LD;
					end
				end
				ST_CHK_LD: begin
					carry_q <= rd_data_q;
					i_q     <= CW'(1);
					state_q <= ST_CHK_CMP;
				end
				ST_CHK_CMP: begin
					if (gt_carry) begin
						sorted_q <= 1'b0;
						state_q  <= ST_FINISH;
					end else if (i_q + CW'(1) < count_q) begin
						carry_q <= rd_data_q;
						i_q     <= i_q + CW'(1);
					end else begin
						sorted_q <= 1'b1;
						state_q  <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						status_q     <= r_status_q;
						position_q   <= r_pos_q;
						data_q       <= r_data_q;
						count_out_q  <= COUNT_W'(count_q);
						sorted_out_q <= sorted_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// an accepted item always takes the sequencer out of idle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an accepted item");

	// the RAM is never written while the sequencer idles
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("RAM write while idle");

	// entry count moves only when an insert or delete completes
	a_count_update: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> state_q == ST_FINISH || state_q == ST_CHK_START)
		else $error("entry count changed outside insert or delete completion");

	// the table never holds more entries than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(count_q) <= CW'(TABLE_DEPTH) |-> count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

endmodule
